// ===== design/taylor_sine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Taylor sine unit assertion macros
// Shared concurrent assertion forms used by the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SINE_UNIT_MACROS_SVH
`define TAYLOR_SINE_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TSU_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("taylor_sine_unit: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define TSU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("taylor_sine_unit: next-cycle check failed");

`endif

// ===== design/tsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit package
// Constants, operand-select codes and the controller/datapath command and
// status structures.
// ----------------------------------------------------------------------------
package tsu_pkg;

   // Default values of the top-level parameters.
   localparam int DEF_MAX_TERMS      = 20;
   localparam int DEF_TERM_FRAC_BITS = 40;

   // Range reduction modulus, 6.2831852 in Q8.24.
   localparam logic [31:0] MOD_Q24   = 32'd105414355;
   localparam int          RED_STEPS = 5;
   localparam int          RED_CNT_W = 3;

   // Threshold register: reset value and the fraction bits it is given in.
   localparam int          THR_W        = 20;
   localparam logic [19:0] THR_RESET    = 20'd10995;
   localparam int          THR_REF_BITS = 40;

   // Fixed-point formats of the channels.
   localparam int ANGLE_FRAC = 24;
   localparam int SINE_FRAC  = 30;
   localparam int N_W        = 6;

   // Reciprocal table of the series denominators (2n)(2n+1).
   localparam int TAB_DEPTH = 32;
   localparam int TAB_IDX_W = 5;
   localparam int DIV_W     = 12;

   // Multiplier operand selection.
   localparam logic [1:0] MUL_SQ   = 2'd0;
   localparam logic [1:0] MUL_REC  = 2'd1;
   localparam logic [1:0] MUL_TERM = 2'd2;

   typedef struct packed {
      logic                 load_angle;
      logic                 red_step;
      logic [RED_CNT_W-1:0] red_shift;
      logic                 init_series;
      logic [1:0]           mul_sel;
      logic                 x2_load;
      logic                 qd_load;
      logic                 c_load;
      logic                 term_load;
      logic                 hit_set;
      logic                 round_load;
      logic                 out_load;
   } cmd_type;

   typedef struct packed {
      logic n_at_max;
      logic term_small;
   } status_type;

endpackage

// ===== design/tsu_channels.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit channels
// Valid/ready interfaces for the angle, result and threshold write channels.
// ----------------------------------------------------------------------------

// Angle channel.
interface tsu_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] angle;
   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

// Result channel.
interface tsu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sine;
   logic [5:0]         terms_used;
   logic               term_limit_hit;
   modport source (output valid, output sine, output terms_used, output term_limit_hit,
                   input ready);
   modport sink   (input valid, input sine, input terms_used, input term_limit_hit,
                   output ready);
endinterface

// Threshold register write channel.
interface tsu_csr_if;
   logic        valid;
   logic        ready;
   logic [19:0] stop_threshold;
   modport source (output valid, output stop_threshold, input ready);
   modport sink   (input valid, input stop_threshold, output ready);
endinterface

// ===== design/tsu_mul.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit multiplier
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial
// products, registered, then summed into the registered 128-bit product.
// ----------------------------------------------------------------------------
module tsu_mul (
   input  logic         clock,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic [127:0] product
);
   logic [63:0]  pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [63:0]  pp00_in, pp01_in, pp10_in, pp11_in;
   logic [127:0] prod_ff, prod_in;

   // First stage: the four partial products.
   always_comb begin
      pp00_in = op_a[31:0]  * op_b[31:0];
      pp01_in = op_a[31:0]  * op_b[63:32];
      pp10_in = op_a[63:32] * op_b[31:0];
      pp11_in = op_a[63:32] * op_b[63:32];
   end

   // Second stage: the partial products are aligned and summed.
   always_comb begin
      prod_in = {pp11_ff, pp00_ff} + {32'd0, pp01_ff, 32'd0} + {32'd0, pp10_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      pp00_ff <= pp00_in;
      pp01_ff <= pp01_in;
      pp10_ff <= pp10_in;
      pp11_ff <= pp11_in;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// ===== design/tsu_datapath.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit datapath
// Range reduction, series term recursion on the shared multiplier, exact
// reciprocal division with one correction step, rounding and the result
// register. Driven by the command structure from the controller.
// ----------------------------------------------------------------------------
`include "taylor_sine_unit_macros.svh"

module tsu_datapath #(
   parameter int MAX_TERMS      = tsu_pkg::DEF_MAX_TERMS,
   parameter int TERM_FRAC_BITS = tsu_pkg::DEF_TERM_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsu_pkg::cmd_type     cmd,
   output tsu_pkg::status_type  status,
   input  logic signed [31:0]   angle,
   input  logic                 csr_we,
   input  logic [19:0]          csr_data,
   output logic signed [31:0]   sine,
   output logic [5:0]           terms_used,
   output logic                 term_limit_hit
);
   import tsu_pkg::*;

   localparam int          F        = TERM_FRAC_BITS;
   localparam int          THR_UP   = (F >= THR_REF_BITS) ? F - THR_REF_BITS : 0;
   localparam int          THR_DN   = (F < THR_REF_BITS) ? THR_REF_BITS - F : 0;
   localparam int          RND_SH   = F - SINE_FRAC;
   localparam logic [63:0] RND_HALF = (64'd1 << RND_SH) >> 1;
   localparam logic [63:0] SAT_MAG  = 64'd1 << SINE_FRAC;
   localparam logic [64:0] TWO_POW64 = 65'd1 << 64;

   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [31:0]        red_ff, red_in;
   logic               aneg_ff, aneg_in;
   logic [63:0]        x2_ff, x2_in;
   logic [63:0]        t_ff, t_in;
   logic               tneg_ff, tneg_in;
   logic [63:0]        sum_ff, sum_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic               hit_ff, hit_in;
   logic [63:0]        qest_ff, qest_in;
   logic [63:0]        qd_ff, qd_in;
   logic [63:0]        c_ff, c_in;
   logic [63:0]        rmag_ff, rmag_in;
   logic               rneg_ff, rneg_in;
   logic signed [31:0] sine_ff, sine_in;
   logic [N_W-1:0]     terms_ff, terms_in;
   logic               limit_ff, limit_in;

   logic [63:0]          recip_tab [TAB_DEPTH];
   logic [DIV_W-1:0]     div_tab [TAB_DEPTH];
   logic [TAB_IDX_W-1:0] n_idx;
   logic [63:0]          op_a, op_b;
   logic [127:0]         product;
   logic [63:0]          prod_frac;
   logic [63:0]          m_val;
   logic [63:0]          thr_scaled;
   logic [31:0]          mod_shifted;
   logic [DIV_W-1:0]     div_sel;
   logic [75:0]          qd_full;
   logic [63:0]          sum_mag;
   logic [63:0]          sat_mag;

   // Reciprocals floor(2^64 / d) of the denominators d = (2n)(2n+1).
   // Entry zero is never read by the series.
   for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_recip
      localparam logic [64:0] DIVISOR = (g == 0) ? 65'd1 : 65'(2 * g * (2 * g + 1));
      localparam logic [64:0] QUO     = TWO_POW64 / DIVISOR;
      assign recip_tab[g] = QUO[63:0];
      assign div_tab[g]   = DIVISOR[DIV_W-1:0];
   end

   assign n_idx       = n_ff[TAB_IDX_W-1:0];
   assign div_sel     = div_tab[n_idx];
   assign m_val       = 64'(red_ff) << (F - ANGLE_FRAC);
   assign thr_scaled  = (64'(thr_ff) << THR_UP) >> THR_DN;
   assign mod_shifted = MOD_Q24 << cmd.red_shift;
   assign prod_frac   = product[F +: 64];
   assign qd_full     = product[127:64] * div_sel;
   assign sum_mag     = sum_ff[63] ? (64'd0 - sum_ff) : sum_ff;
   assign sat_mag     = (rmag_ff > SAT_MAG) ? SAT_MAG : rmag_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.mul_sel)
         MUL_SQ: begin
            op_a = m_val;
            op_b = m_val;
         end
         MUL_REC: begin
            op_a = x2_ff;
            op_b = recip_tab[n_idx];
         end
         MUL_TERM: begin
            op_a = t_ff;
            op_b = c_ff;
         end
         default: begin
            op_a = 64'd0;
            op_b = 64'd0;
         end
      endcase
   end

   tsu_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // Status towards the controller.
   assign status.n_at_max   = (n_ff >= N_W'(MAX_TERMS));
   assign status.term_small = (prod_frac <= thr_scaled);

   // Next-state logic of the working registers.
   always_comb begin
      thr_in   = thr_ff;
      red_in   = red_ff;
      aneg_in  = aneg_ff;
      x2_in    = x2_ff;
      t_in     = t_ff;
      tneg_in  = tneg_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      hit_in   = hit_ff;
      qest_in  = qest_ff;
      qd_in    = qd_ff;
      c_in     = c_ff;
      rmag_in  = rmag_ff;
      rneg_in  = rneg_ff;
      sine_in  = sine_ff;
      terms_in = terms_ff;
      limit_in = limit_ff;

      // Threshold register write.
      if (csr_we) begin
         thr_in = csr_data;
      end

      // Take the magnitude and sign of a new angle.
      if (cmd.load_angle) begin
         aneg_in = angle[31];
         red_in  = angle[31] ? (32'd0 - angle) : angle;
         hit_in  = 1'b0;
      end

      // One restoring step of the reduction against the shifted modulus.
      if (cmd.red_step) begin
         if (red_ff >= mod_shifted) begin
            red_in = red_ff - mod_shifted;
         end
      end

      // The first term is the reduced angle itself.
      if (cmd.init_series) begin
         t_in    = m_val;
         tneg_in = aneg_ff;
         sum_in  = aneg_ff ? (64'd0 - m_val) : m_val;
         n_in    = N_W'(1);
      end

      if (cmd.x2_load) begin
         x2_in = prod_frac;
      end

      // Quotient estimate from the reciprocal, and its back-multiplied value.
      if (cmd.qd_load) begin
         qest_in = product[127:64];
         qd_in   = qd_full[63:0];
      end

      // The estimate is at most one short: correct it with the remainder.
      if (cmd.c_load) begin
         c_in = ((x2_ff - qd_ff) >= 64'(div_sel)) ? (qest_ff + 64'd1) : qest_ff;
      end

      // New term, alternating sign, accumulated into the sum.
      if (cmd.term_load) begin
         t_in    = prod_frac;
         tneg_in = !tneg_ff;
         sum_in  = tneg_ff ? (sum_ff + prod_frac) : (sum_ff - prod_frac);
         n_in    = n_ff + N_W'(1);
      end

      if (cmd.hit_set) begin
         hit_in = 1'b1;
      end

      // Round the magnitude half away from zero to the output fraction.
      if (cmd.round_load) begin
         rneg_in = sum_ff[63];
         rmag_in = (sum_mag + RND_HALF) >> RND_SH;
      end

      // Saturate and load the result register.
      if (cmd.out_load) begin
         sine_in  = rneg_ff ? signed'(32'd0 - sat_mag[31:0]) : signed'(sat_mag[31:0]);
         terms_in = n_ff;
         limit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      aneg_ff  <= aneg_in;
      x2_ff    <= x2_in;
      t_ff     <= t_in;
      tneg_ff  <= tneg_in;
      sum_ff   <= sum_in;
      n_ff     <= n_in;
      hit_ff   <= hit_in;
      qest_ff  <= qest_in;
      qd_ff    <= qd_in;
      c_ff     <= c_in;
      rmag_ff  <= rmag_in;
      rneg_ff  <= rneg_in;
      sine_ff  <= sine_in;
      terms_ff <= terms_in;
      limit_ff <= limit_in;
   end

   assign sine           = sine_ff;
   assign terms_used     = terms_ff;
   assign term_limit_hit = limit_ff;

   // The reduction must have finished below the modulus.
   `TSU_ASSERT_IMP(a_reduced_below_mod, clock, reset, cmd.init_series, red_ff < MOD_Q24)
   // The reciprocal estimate never overshoots the true quotient.
   `TSU_ASSERT_IMP(a_qest_not_over, clock, reset, cmd.c_load, qd_ff <= x2_ff)

endmodule

// ===== design/tsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit controller
// State machine that sequences reduction, squaring, the per-term division and
// multiplication, rounding and the hand-over to the result register.
// ----------------------------------------------------------------------------
`include "taylor_sine_unit_macros.svh"

module tsu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tsu_pkg::cmd_type    cmd,
   input  tsu_pkg::status_type status
);
   import tsu_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RED      = 4'd1;
   localparam logic [3:0] ST_SQ_MUL   = 4'd2;
   localparam logic [3:0] ST_SQ_WAIT  = 4'd3;
   localparam logic [3:0] ST_SQ_DONE  = 4'd4;
   localparam logic [3:0] ST_TEST     = 4'd5;
   localparam logic [3:0] ST_REC_WAIT = 4'd6;
   localparam logic [3:0] ST_QD       = 4'd7;
   localparam logic [3:0] ST_CORR     = 4'd8;
   localparam logic [3:0] ST_T_MUL    = 4'd9;
   localparam logic [3:0] ST_T_WAIT   = 4'd10;
   localparam logic [3:0] ST_T_UPD    = 4'd11;
   localparam logic [3:0] ST_RND      = 4'd12;
   localparam logic [3:0] ST_OUT      = 4'd13;

   localparam logic [RED_CNT_W-1:0] RED_FIRST = RED_CNT_W'(RED_STEPS - 1);

   logic [3:0]           state_ff, state_in;
   logic [RED_CNT_W-1:0] red_cnt_ff, red_cnt_in;
   logic                 valid_ff, valid_in;
   logic                 accept;
   logic                 out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;

   // Command decode and next state.
   always_comb begin
      state_in   = state_ff;
      red_cnt_in = red_cnt_ff;
      cmd        = '0;
      cmd.red_shift = red_cnt_ff;
      cmd.mul_sel   = MUL_SQ;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_angle = 1'b1;
               red_cnt_in     = RED_FIRST;
               state_in       = ST_RED;
            end
         end
         ST_RED: begin
            cmd.red_step = 1'b1;
            red_cnt_in   = red_cnt_ff - RED_CNT_W'(1);
            if (red_cnt_ff == '0) begin
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            cmd.mul_sel     = MUL_SQ;
            cmd.init_series = 1'b1;
            state_in        = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            state_in = ST_SQ_DONE;
         end
         ST_SQ_DONE: begin
            cmd.x2_load = 1'b1;
            state_in    = ST_TEST;
         end
         ST_TEST: begin
            cmd.mul_sel = MUL_REC;
            if (status.n_at_max) begin
               cmd.hit_set = 1'b1;
               state_in    = ST_RND;
            end else begin
               state_in = ST_REC_WAIT;
            end
         end
         ST_REC_WAIT: begin
            state_in = ST_QD;
         end
         ST_QD: begin
            cmd.qd_load = 1'b1;
            state_in    = ST_CORR;
         end
         ST_CORR: begin
            cmd.c_load = 1'b1;
            state_in   = ST_T_MUL;
         end
         ST_T_MUL: begin
            cmd.mul_sel = MUL_TERM;
            state_in    = ST_T_WAIT;
         end
         ST_T_WAIT: begin
            state_in = ST_T_UPD;
         end
         ST_T_UPD: begin
            cmd.term_load = 1'b1;
            state_in      = status.term_small ? ST_RND : ST_TEST;
         end
         ST_RND: begin
            cmd.round_load = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on a load, cleared when the item is taken.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         red_cnt_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         red_cnt_ff <= red_cnt_in;
         valid_ff   <= valid_in;
      end
   end

   // A waiting result is never overwritten.
   `TSU_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !valid_ff || rsp_ready)
   // An accepted angle starts the reduction at its widest shift.
   `TSU_ASSERT_NEXT(a_accept_starts_red, clock, reset, accept,
                    state_ff == ST_RED && red_cnt_ff == RED_FIRST)

endmodule

// ===== design/taylor_sine_unit.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit
// Sine of a Q8.24 angle by range reduction and a truncated Taylor series.
// ----------------------------------------------------------------------------
// Use of the block:
//   req_chan carries one angle per item (signed Q8.24 radians). rsp_chan
//   returns sine (signed Q2.30, saturated to plus or minus one), the number
//   of series terms added and a flag that is set when the term cap ended the
//   sum. csr_chan writes the stop threshold; it is always ready and should
//   only be written while no item is in flight.
//   One item is worked on at a time. The angle is reduced by restoring steps
//   against the shifted modulus, then squared, and each further term is
//   formed on the one shared 64 x 64 multiplier (reciprocal product, quotient
//   correction, term product). The default cap is 20 terms. A new angle is
//   accepted in the cycle after the result has been loaded.
//   A finished result waits in the output register while the next angle is
//   taken; if the receiver stalls with a result still held, the block holds
//   its next result until the register frees.
//   Synchronous reset returns the controller to idle, drops rsp valid and
//   sets the threshold to 10995 (about 1e-8).
// ----------------------------------------------------------------------------
module taylor_sine_unit #(
   parameter int MAX_TERMS      = tsu_pkg::DEF_MAX_TERMS,
   parameter int TERM_FRAC_BITS = tsu_pkg::DEF_TERM_FRAC_BITS
) (
   input logic       clock,
   input logic       reset,
   tsu_req_if.sink   req_chan,
   tsu_rsp_if.source rsp_chan,
   tsu_csr_if.sink   csr_chan
);
   import tsu_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The threshold register takes a write in any cycle.
   assign csr_chan.ready = 1'b1;

   tsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tsu_datapath #(
      .MAX_TERMS      (MAX_TERMS),
      .TERM_FRAC_BITS (TERM_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .angle          (req_chan.angle),
      .csr_we         (csr_chan.valid),
      .csr_data       (csr_chan.stop_threshold),
      .sine           (rsp_chan.sine),
      .terms_used     (rsp_chan.terms_used),
      .term_limit_hit (rsp_chan.term_limit_hit)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Taylor sine unit testbench
// Drives angles into the unit under random idling and back-pressure and
// compares every result against an independent fixed-point sine predictor,
// over several stop threshold settings, including both extremes.
// ----------------------------------------------------------------------------
module tb;

   localparam int     CLK_PERIOD      = 10;
   localparam int     TERM_CAP        = tsu_pkg::DEF_MAX_TERMS;
   localparam int     FRAC_BITS       = tsu_pkg::DEF_TERM_FRAC_BITS;
   localparam int     ROUND_SHIFT     = FRAC_BITS - tsu_pkg::SINE_FRAC;
   localparam int     MAX_GAP         = 17;
   localparam int     HOLD_CYCLES     = 600;
   localparam int     FLOOD_ITEMS     = 12;
   // Worst-case latency at the term cap, with some margin.
   localparam int     DRAIN_CYCLES    = 160;
   localparam int     SETTLE_CYCLES   = 4;
   localparam int     ITEMS_PER_PHASE = 230;
   localparam int     PHASES          = 7;
   localparam longint WATCHDOG_NS     = 15_000_000;
   localparam logic signed [31:0] MODULUS = tsu_pkg::MOD_Q24;

   typedef struct packed {
      logic signed [31:0] sine;
      logic [5:0]         terms_used;
      logic               term_limit_hit;
   } sine_result_type;

   // Expected results, worked out in order of acceptance and checked in order.
   class sine_scoreboard;
      sine_result_type pending_sines[$];
      logic [19:0]     threshold;
      int              checked;
      int              failures;
      int              cap_hits;
      int              fewest_terms;
      int              most_terms;

      function new();
         threshold    = tsu_pkg::THR_RESET;
         checked      = 0;
         failures     = 0;
         cap_hits     = 0;
         fewest_terms = 64;
         most_terms   = 0;
      endfunction

      function void set_threshold(logic [19:0] value);
         threshold = value;
      endfunction

      function int outstanding();
         return pending_sines.size();
      endfunction

      // Range reduction, then the series by term recursion on term magnitudes,
      // with 64-bit wrap-around for the signed running sum.
      function sine_result_type predict_sine(logic [31:0] raw);
         logic [32:0]     amag;
         logic [63:0]     m, x2, t, c, d, sum, mag, thr;
         logic [127:0]    prod;
         bit              tneg, neg, hit, done;
         int              n;
         sine_result_type r;
         amag = raw[31] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
         m    = (64'(amag) % 64'(tsu_pkg::MOD_Q24)) << (FRAC_BITS - tsu_pkg::ANGLE_FRAC);
         prod = {64'd0, m} * {64'd0, m};
         x2   = 64'(prod >> FRAC_BITS);
         thr  = 64'(threshold) << (FRAC_BITS - tsu_pkg::THR_REF_BITS);
         t    = m;
         tneg = raw[31];
         sum  = raw[31] ? -m : m;
         n    = 1;
         hit  = 1'b0;
         done = 1'b0;
         while (!done) begin
            if (n >= TERM_CAP) begin
               hit  = 1'b1;
               done = 1'b1;
            end else begin
               d    = 64'(2 * n) * 64'(2 * n + 1);
               c    = x2 / d;
               prod = {64'd0, t} * {64'd0, c};
               t    = 64'(prod >> FRAC_BITS);
               tneg = !tneg;
               sum  = tneg ? sum - t : sum + t;
               n++;
               if (t <= thr) done = 1'b1;
            end
         end
         // Round half away from zero to Q2.30 and saturate to plus or minus one.
         neg = sum[63];
         mag = neg ? -sum : sum;
         mag = (mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
         if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
         r.sine           = neg ? 32'(-mag) : 32'(mag);
         r.terms_used     = n[5:0];
         r.term_limit_hit = hit;
         return r;
      endfunction

      function void note_angle(logic [31:0] raw);
         pending_sines.push_back(predict_sine(raw));
      endfunction

      function void check_result(sine_result_type got);
         sine_result_type want;
         if (pending_sines.size() == 0) begin
            $error("result with no angle outstanding: sine %0d", $signed(got.sine));
            failures++;
            return;
         end
         want = pending_sines.pop_front();
         checked++;
         if (want.term_limit_hit) cap_hits++;
         if (want.terms_used < fewest_terms) fewest_terms = want.terms_used;
         if (want.terms_used > most_terms) most_terms = want.terms_used;
         if (got.sine !== want.sine) begin
            $error("sine: expected %0d, actual %0d", $signed(want.sine), $signed(got.sine));
            failures++;
         end
         if (got.terms_used !== want.terms_used) begin
            $error("terms_used: expected %0d, actual %0d", want.terms_used, got.terms_used);
            failures++;
         end
         if (got.term_limit_hit !== want.term_limit_hit) begin
            $error("term_limit_hit: expected %0d, actual %0d",
                   want.term_limit_hit, got.term_limit_hit);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   hold_requested = 1'b0;
   bit   sender_eager   = 1'b0;
   int   phases_run     = 0;

   sine_scoreboard sine_sb = new();

   tsu_req_if req_bus ();
   tsu_rsp_if rsp_bus ();
   tsu_csr_if csr_bus ();

   taylor_sine_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Sender gap, with occasional stretches of back-to-back items.
   function automatic int next_sender_gap();
      if ($urandom_range(0, 31) == 0) sender_eager = !sender_eager;
      return sender_eager ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Half the angles within one turn, the rest full-range values, values close
   // to multiples of the modulus and very small angles.
   function automatic logic signed [31:0] draw_angle();
      int     kind;
      longint k;
      longint v;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3, 4: begin
            v = longint'($urandom_range(0, 2 * (MODULUS - 1))) - (MODULUS - 1);
         end
         5, 6: begin
            v = $signed(32'($urandom));
         end
         7: begin
            k = $urandom_range(0, 20);
            v = k * MODULUS + longint'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 1) != 0) v = -v;
         end
         default: begin
            v = $urandom_range(0, 1 << 16);
            if ($urandom_range(0, 1) != 0) v = -v;
         end
      endcase
      return 32'(v);
   endfunction

   // Offer one angle after the given gap and wait until it is accepted.
   task automatic send_angle(input logic signed [31:0] angle, input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.angle <= angle;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sine_sb.note_angle(angle);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sine_sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [19:0] value);
      csr_bus.stop_threshold <= value;
      csr_bus.valid          <= 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      sine_sb.set_threshold(value);
   endtask

   // Stimulus: corner angles first, then random phases under several thresholds.
   initial begin : angle_source
      logic signed [31:0] corner_angles[$];
      logic [19:0]        thr_value;
      corner_angles = {32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       MODULUS, -MODULUS, MODULUS - 1, 1 - MODULUS, MODULUS + 1,
                       20 * MODULUS, -20 * MODULUS, 32'sd26353589, -32'sd26353589,
                       32'sd52707179, 32'sd79060768, 32'sd16777216, 32'sd1048576,
                       32'sd1024, -32'sd50331648};
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.angle          <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.stop_threshold <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_angles[i]) send_angle(corner_angles[i], next_sender_gap());

      for (int phase = 0; phase < PHASES; phase++) begin
         // The first phase runs on the reset threshold.
         if (phase > 0) begin
            drain_results();
            case (phase)
               1:       thr_value = 20'd0;
               2:       thr_value = 20'hF_FFFF;
               3:       thr_value = 20'($urandom_range(1, 20'hF_FFFE));
               4:       thr_value = 20'd1;
               5:       thr_value = tsu_pkg::THR_RESET;
               default: thr_value = 20'($urandom_range(0, 4095));
            endcase
            write_threshold(thr_value);
         end
         phases_run++;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // Midway through one phase the receiver holds off while items
            // keep coming, so the unit fills and stalls its input.
            if (phase == 2 && k == ITEMS_PER_PHASE / 2) begin
               hold_requested = 1'b1;
               repeat (FLOOD_ITEMS) send_angle(draw_angle(), 0);
            end
            send_angle(draw_angle(), next_sender_gap());
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sine_sb.outstanding() != 0) begin
         $error("%0d expected results never arrived", sine_sb.outstanding());
         sine_sb.failures++;
      end
      $display("Checked %0d sine results over %0d stop thresholds, zero and maximum included.",
               sine_sb.checked, phases_run);
      $display("Term cap reached %0d times; terms used ranged from %0d to %0d.",
               sine_sb.cap_hits, sine_sb.fewest_terms, sine_sb.most_terms);
      if (sine_sb.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Result receiver: random stalls, stretches of none, and one long hold-off.
   initial begin : result_sink
      int              stall;
      bit              eager;
      sine_result_type got;
      eager = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_requested) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_requested = 1'b0;
         end
         if ($urandom_range(0, 31) == 0) eager = !eager;
         stall = eager ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.sine           = rsp_bus.sine;
         got.terms_used     = rsp_bus.terms_used;
         got.term_limit_hit = rsp_bus.term_limit_hit;
         sine_sb.check_result(got);
      end
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("Timed out with %0d results outstanding.", sine_sb.outstanding());
      $display("status: fail");
      $finish;
   end

endmodule
